// ===== src/assert_macros.svh =====
// Assertion macros used by the top level of the polynomial evaluator.
// No dependencies; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== src/cpe_pkg.sv =====
// Shared types, constants and the saturation function of the polynomial evaluator.
// No dependencies; used by cpe_mac and complex_polynomial_evaluator.
package cpe_pkg;

   // Q8.24 fixed point: products are shifted right by this many bits.
   localparam int Q_SHIFT = 24;
   localparam int DATA_W  = 32;
   localparam int PROD_W  = 2 * DATA_W - Q_SHIFT;
   localparam int SUM_W   = PROD_W + 1;

   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32'sh7FFF_FFFF);
   localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

   // Request kinds carried on req_kind.
   typedef enum logic {
      KIND_WRITE = 1'b0,
      KIND_EVAL  = 1'b1
   } req_kind_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_ADD
   } state_type;

   // Step controls handed from the sequencer to the arithmetic unit.
   typedef struct packed {
      logic load;
      logic mul;
      logic add;
   } mac_ctrl_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] val;
      logic                     ovf;
   } sat_type;

   // Clamp a wide sum to the signed 32-bit range and flag any clamp.
   function automatic sat_type sat32(input logic signed [SUM_W-1:0] x);
      sat_type res;
      if (x > SAT_HI) begin
         res.val = 32'sh7FFF_FFFF;
         res.ovf = 1'b1;
      end else if (x < SAT_LO) begin
         res.val = 32'sh8000_0000;
         res.ovf = 1'b1;
      end else begin
         res.val = x[DATA_W-1:0];
         res.ovf = 1'b0;
      end
      return res;
   endfunction

endpackage

// ===== src/cpe_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; holds the coefficient table of the evaluator.
module cpe_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/cpe_mac.sv =====
// Complex multiply-accumulate unit for one Horner step: acc = sat(sat(acc * z) + coef).
// Depends on cpe_pkg for the control struct and the saturation function.
module cpe_mac
   import cpe_pkg::*;
(
   input  logic                     clock,
   input  mac_ctrl_type             ctrl,
   input  logic signed [DATA_W-1:0] z_re,
   input  logic signed [DATA_W-1:0] z_im,
   input  logic signed [DATA_W-1:0] coef_re,
   input  logic signed [DATA_W-1:0] coef_im,
   output logic signed [DATA_W-1:0] acc_re,
   output logic signed [DATA_W-1:0] acc_im,
   output logic                     overflow
);

   logic signed [DATA_W-1:0]   acc_re_ff, acc_im_ff;
   logic signed [DATA_W-1:0]   acc_re_in, acc_im_in;
   logic                       ovf_ff, ovf_in;
   logic signed [PROD_W-1:0]   prod_ff [4];
   logic signed [2*DATA_W-1:0] m_rr, m_ii, m_ri, m_ir;
   logic signed [SUM_W-1:0]    part_re, part_im, add_re, add_im;
   sat_type                    sat_pre, sat_pim, sat_re, sat_im;

   // Four real products, floored to Q16.24 by dropping the low fraction bits.
   assign m_rr = acc_re_ff * z_re;
   assign m_ii = acc_im_ff * z_im;
   assign m_ri = acc_re_ff * z_im;
   assign m_ir = acc_im_ff * z_re;

   always_ff @(posedge clock) begin
      if (ctrl.mul) begin
         prod_ff[0] <= m_rr[2*DATA_W-1:Q_SHIFT];
         prod_ff[1] <= m_ii[2*DATA_W-1:Q_SHIFT];
         prod_ff[2] <= m_ri[2*DATA_W-1:Q_SHIFT];
         prod_ff[3] <= m_ir[2*DATA_W-1:Q_SHIFT];
      end
   end

   // Combine the products, clamp, then add the coefficient and clamp again.
   always_comb begin
      part_re = SUM_W'(prod_ff[0]) - SUM_W'(prod_ff[1]);
      part_im = SUM_W'(prod_ff[2]) + SUM_W'(prod_ff[3]);
      sat_pre = sat32(part_re);
      sat_pim = sat32(part_im);
      add_re  = SUM_W'(sat_pre.val) + SUM_W'(coef_re);
      add_im  = SUM_W'(sat_pim.val) + SUM_W'(coef_im);
      sat_re  = sat32(add_re);
      sat_im  = sat32(add_im);
   end

   // Accumulator update: loaded with the leading coefficient, then one step per term.
   always_comb begin
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      ovf_in    = ovf_ff;
      if (ctrl.load) begin
         acc_re_in = coef_re;
         acc_im_in = coef_im;
         ovf_in    = 1'b0;
      end else if (ctrl.add) begin
         acc_re_in = sat_re.val;
         acc_im_in = sat_im.val;
         ovf_in    = ovf_ff | sat_pre.ovf | sat_pim.ovf | sat_re.ovf | sat_im.ovf;
      end
   end

   always_ff @(posedge clock) begin
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
      ovf_ff    <= ovf_in;
   end

   assign acc_re   = acc_re_ff;
   assign acc_im   = acc_im_ff;
   assign overflow = ovf_ff;

endmodule

// ===== src/complex_polynomial_evaluator.sv =====
// Top level of the complex polynomial evaluator: sequencer, coefficient store, valid bits.
// Depends on cpe_pkg, cpe_ram, cpe_mac and assert_macros.svh.
//
// Usage:
//  - A request is taken when start is high and busy is low. With req_kind low it writes
//    coefficient req_coef_index (req_coef_re, req_coef_im) in that one cycle and gives no
//    response; indexes beyond the table are dropped.
//  - With req_kind high it evaluates the polynomial at (req_z_re, req_z_im) by Horner's
//    rule up to the power in the degree register, written through csr_wr_en and csr_wr_data
//    while the block is idle; the user must ensure this, as the block does not enforce it.
//  - An evaluation keeps busy high while it loads the leading coefficient from the RAM,
//    then runs each term as a registered complex multiply followed by a clamp and
//    coefficient add. The RAM's registered read is fetched under the multiply.
//  - rsp_strobe is registered from the final load or add step, rises as busy falls and stays
//    high for exactly one cycle, marking rsp_value_re, rsp_value_im and rsp_overflow. The
//    next request may be taken in that same cycle. The receiver cannot stall the response.
//  - Reset clears the degree register to zero and marks every coefficient as zero at once
//    through one valid bit per entry; no clearing pass is needed.
`include "assert_macros.svh"

module complex_polynomial_evaluator
   import cpe_pkg::*;
#(
   parameter int MAX_TERMS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_kind,
   input  logic [3:0]               req_coef_index,
   input  logic signed [DATA_W-1:0] req_coef_re,
   input  logic signed [DATA_W-1:0] req_coef_im,
   input  logic signed [DATA_W-1:0] req_z_re,
   input  logic signed [DATA_W-1:0] req_z_im,
   output logic                     rsp_strobe,
   output logic signed [DATA_W-1:0] rsp_value_re,
   output logic signed [DATA_W-1:0] rsp_value_im,
   output logic                     rsp_overflow,
   input  logic                     csr_wr_en,
   input  logic [3:0]               csr_wr_data
);

   localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         k_ff, k_in;
   logic [3:0]               degree_ff;
   logic [MAX_TERMS-1:0]     valid_ff;
   logic                     rd_valid_ff;
   logic                     strobe_ff, strobe_in;
   logic signed [DATA_W-1:0] z_re_ff, z_im_ff;
   logic                     accept_eval, accept_wr, wr_in_range;
   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr, wr_addr, deg_sat;
   logic [2*DATA_W-1:0]      rd_data;
   logic signed [DATA_W-1:0] coef_re, coef_im;
   mac_ctrl_type             ctrl;

   // Request decode.
   assign accept_eval = start && !busy && (req_kind == KIND_EVAL);
   assign accept_wr   = start && !busy && (req_kind == KIND_WRITE);
   assign wr_in_range = 32'(req_coef_index) < MAX_TERMS;
   assign wr_addr     = IDX_W'(req_coef_index);
   assign deg_sat     = (32'(degree_ff) > MAX_TERMS - 1) ? IDX_W'(MAX_TERMS - 1)
                                                         : IDX_W'(degree_ff);

   // Degree register.
   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= '0;
      end else if (csr_wr_en) begin
         degree_ff <= csr_wr_data;
      end
   end

   // Valid bits: an entry never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (accept_wr && wr_in_range) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // Evaluation point, held for the whole evaluation.
   always_ff @(posedge clock) begin
      if (accept_eval) begin
         z_re_ff <= req_z_re;
         z_im_ff <= req_z_im;
      end
   end

   // Coefficient store; writes only happen while idle, so no read can overlap them.
   cpe_ram #(
      .WIDTH (2 * DATA_W),
      .DEPTH (MAX_TERMS)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (accept_wr && wr_in_range),
      .wr_addr (wr_addr),
      .wr_data ({req_coef_re, req_coef_im}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign coef_re = rd_valid_ff ? rd_data[2*DATA_W-1:DATA_W] : '0;
   assign coef_im = rd_valid_ff ? rd_data[DATA_W-1:0] : '0;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept_eval) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD, ST_ADD: begin
            state_in = (k_ff == '0) ? ST_IDLE : ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_ADD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs: RAM reads, term counter and step controls.
   always_comb begin
      rd_en     = 1'b0;
      rd_addr   = k_ff - IDX_W'(1);
      k_in      = k_ff;
      strobe_in = 1'b0;
      ctrl      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept_eval) begin
               rd_en   = 1'b1;
               rd_addr = deg_sat;
               k_in    = deg_sat;
            end
         end
         ST_LOAD: begin
            ctrl.load = 1'b1;
            if (k_ff == '0) begin
               strobe_in = 1'b1;
            end else begin
               rd_en = 1'b1;
               k_in  = k_ff - IDX_W'(1);
            end
         end
         ST_MUL: begin
            ctrl.mul = 1'b1;
         end
         ST_ADD: begin
            ctrl.add = 1'b1;
            if (k_ff == '0) begin
               strobe_in = 1'b1;
            end else begin
               rd_en = 1'b1;
               k_in  = k_ff - IDX_W'(1);
            end
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
   end

   // Complex multiply-accumulate.
   cpe_mac u_mac (
      .clock    (clock),
      .ctrl     (ctrl),
      .z_re     (z_re_ff),
      .z_im     (z_im_ff),
      .coef_re  (coef_re),
      .coef_im  (coef_im),
      .acc_re   (rsp_value_re),
      .acc_im   (rsp_value_im),
      .overflow (rsp_overflow)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

   // An evaluation request always occupies the sequencer.
   `ASSERT_NEXT(a_eval_busy, clock, reset, accept_eval, busy)
   // Each evaluation gives a single response.
   `ASSERT_NEXT(a_single_rsp, clock, reset, rsp_strobe, !rsp_strobe)
   // The sequencer only goes idle by delivering a response.
   `ASSERT_IMPLIES(a_end_rsp, clock, reset, $fell(busy), rsp_strobe)
   // A coefficient write gives no response.
   `ASSERT_NEXT(a_wr_silent, clock, reset, accept_wr, !rsp_strobe)

endmodule
